/* sv/atan2a_pkg.sv */
`default_nettype none
package atan2a_pkg;

	// input and magnitude widths
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int RATIO_W  = 16;

	// polynomial datapath width, Q1.24 terms
	localparam int POLY_W   = 25;
	localparam int PROD_W   = POLY_W + RATIO_W;

	// base angle in Q.29 and its divider remainder
	localparam int BASE_W   = 29;
	localparam int REM_W    = POLY_W + 1;
	localparam int ANGLE_W  = 32;
	localparam int OUT_W    = 16;

	// coefficients, round(c * 2^24)
	localparam logic [POLY_W-1:0] C1 = 25'd5;
	localparam logic [POLY_W-1:0] C2 = 25'd16776773;
	localparam logic [POLY_W-1:0] C3 = 25'd2473634;
	localparam logic [POLY_W-1:0] C4 = 25'd5200625;
	localparam logic [POLY_W-1:0] C5 = 25'd843924;
	localparam logic [POLY_W-1:0] C6 = 25'd2467994;
	localparam logic [POLY_W-1:0] C7 = 25'd10812313;
	localparam logic [POLY_W-1:0] ONE_Q24 = 25'd16777216;

	localparam logic signed [ANGLE_W-1:0] PI_Q29      = 32'sd1686629713;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = 32'sd843314857;
	localparam logic [OUT_W-1:0]          PI_Q13      = 16'd25736;

	// total cycles from accepted start to done
	localparam int LATENCY = 52;

	// octant and quadrant flags that travel with each item
	typedef struct packed {
		logic swap;
		logic xneg;
		logic yneg;
	} oct_t;

endpackage
`default_nettype wire

/* sv/atan2_approximation.sv */
`default_nettype none
// four-quadrant arctangent of a signed 16-bit (y, x) pair, returned as a signed
// Q3.13 angle in radians within plus or minus pi (25736). a transfer in is taken
// on any edge with start high; busy never rises, so a new pair may follow every
// cycle. each result appears on angle for one cycle with done high, in input
// order. the receiver cannot stall the block and nothing is buffered: the
// pipeline moves every cycle. the depth is set by two bit-per-stage dividers,
// 16 stages for the magnitude ratio and 29 for the rational polynomial's
// quotient, plus the Horner multiplies.
module atan2_approximation (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [atan2a_pkg::SAMPLE_W-1:0] y_value,
	input  wire logic signed [atan2a_pkg::SAMPLE_W-1:0] x_value,
	output logic                                       done,
	output logic signed [atan2a_pkg::OUT_W-1:0]        angle
);
	import atan2a_pkg::*;

	// the pipeline never stalls
	assign busy = 1'b0;

	// ratio of smaller to larger magnitude, Q0.16
	logic               r_v;
	logic [RATIO_W-1:0] r_val;
	oct_t               r_oct;

	atan2a_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (start),
		.y      (y_value),
		.x      (x_value),
		.out_v  (r_v),
		.ratio  (r_val),
		.oct    (r_oct)
	);

	// Horner evaluation, at most one multiply per polynomial in each stage
	logic [PROD_W-1:0] pn1, pn2, pn3, pn4, pd1, pd2;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [RATIO_W-1:0] r_s1, r_s2, r_s3;
	oct_t               oct_s1, oct_s2, oct_s3, oct_s4;
	logic [POLY_W-1:0]  tn_s1, tn_s2, tn_s3, num_s4;
	logic [POLY_W-1:0]  td_s1, den_s2, den_s3, den_s4;

	assign pn1 = PROD_W'(C5) * PROD_W'(r_val);
	assign pd1 = PROD_W'(C7) * PROD_W'(r_val);
	assign pn2 = PROD_W'(tn_s1) * PROD_W'(r_s1);
	assign pd2 = PROD_W'(td_s1) * PROD_W'(r_s1);
	assign pn3 = PROD_W'(tn_s2) * PROD_W'(r_s2);
	assign pn4 = PROD_W'(tn_s3) * PROD_W'(r_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= r_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// c4 - c5 r, c6 + c7 r
		tn_s1  <= C4 - pn1[PROD_W-1:RATIO_W];
		td_s1  <= C6 + pd1[PROD_W-1:RATIO_W];
		r_s1   <= r_val;
		oct_s1 <= r_oct;
		// c3 + t r, den = 1 + t r
		tn_s2  <= C3 + pn2[PROD_W-1:RATIO_W];
		den_s2 <= ONE_Q24 + pd2[PROD_W-1:RATIO_W];
		r_s2   <= r_s1;
		oct_s2 <= oct_s1;
		// c2 + t r
		tn_s3  <= C2 + pn3[PROD_W-1:RATIO_W];
		den_s3 <= den_s2;
		r_s3   <= r_s2;
		oct_s3 <= oct_s2;
		// numerator c1 + t r
		num_s4 <= C1 + pn4[PROD_W-1:RATIO_W];
		den_s4 <= den_s3;
		oct_s4 <= oct_s3;
	end

	// base angle in [0, pi/4], Q.29
	logic              q_v;
	logic [BASE_W-1:0] q_base;
	oct_t              q_oct;

	atan2a_quot u_quot (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s4),
		.num     (num_s4),
		.den     (den_s4),
		.oct_in  (oct_s4),
		.out_v   (q_v),
		.base    (q_base),
		.oct_out (q_oct)
	);

	// octant reflection, then quadrant mirror, then sign
	logic signed [ANGLE_W-1:0] a0, a1, a2, a3;
	assign a0 = $signed({{(ANGLE_W-BASE_W){1'b0}}, q_base});
	assign a1 = q_oct.swap ? (HALF_PI_Q29 - a0) : a0;
	assign a2 = q_oct.xneg ? (PI_Q29 - a1) : a1;
	assign a3 = q_oct.yneg ? -a2 : a2;

	logic                      v_s5;
	logic signed [ANGLE_W-1:0] a_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= q_v;
		end
	end

	always_ff @(posedge clk) begin
		a_s5 <= a3;
	end

	// round the magnitude to Q3.13, ties away from zero, clamp at pi
	logic [ANGLE_W-1:0] mag, mag_rnd;
	logic [OUT_W-1:0]   mq, mc;
	logic               neg;

	assign neg     = a_s5[ANGLE_W-1];
	assign mag     = neg ? ANGLE_W'(-a_s5) : ANGLE_W'(a_s5);
	assign mag_rnd = mag + ANGLE_W'(32768);
	assign mq      = mag_rnd[ANGLE_W-1:ANGLE_W-OUT_W];
	assign mc      = (mq > PI_Q13) ? PI_Q13 : mq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		angle <= neg ? $signed(OUT_W'(16'd0 - mc)) : $signed(mc);
	end

	// every result comes from an earlier transfer in, at the LATENCY offset
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done without a matching transfer in");

	// angle never leaves plus or minus pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle <= $signed(PI_Q13)) && (angle >= -$signed(PI_Q13)))
		else $error("angle out of range");

	// a non-negative angle before rounding stays non-negative after it
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !a_s5[ANGLE_W-1]) |=> (done && !angle[OUT_W-1]))
		else $error("angle sign flipped in rounding");

endmodule
`default_nettype wire

/* sv/atan2a_ratio.sv */
`default_nettype none
module atan2a_ratio (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_v,
	input  wire logic signed [atan2a_pkg::SAMPLE_W-1:0] y,
	input  wire logic signed [atan2a_pkg::SAMPLE_W-1:0] x,
	output logic                                    out_v,
	output logic [atan2a_pkg::RATIO_W-1:0]          ratio,
	output atan2a_pkg::oct_t                        oct
);
	import atan2a_pkg::*;

	localparam int STEPS = RATIO_W;

	logic [MAG_W-1:0] ay, ax;
	logic             yneg, xneg;

	// stage 0 holds min/max, stages 1..STEPS are one quotient bit each
	logic             v_s    [0:STEPS];
	logic [MAG_W-1:0] rem_s  [0:STEPS];
	logic [MAG_W-1:0] mx_s   [0:STEPS];
	logic [RATIO_W-1:0] q_s  [0:STEPS];
	logic             fz_s   [0:STEPS];
	logic             sat_s  [0:STEPS];
	oct_t             oct_s  [0:STEPS];

	assign yneg = y[SAMPLE_W-1];
	assign xneg = x[SAMPLE_W-1];
	assign ay = yneg ? (MAG_W'(0) - {y[SAMPLE_W-1], y}) : {1'b0, y};
	assign ax = xneg ? (MAG_W'(0) - {x[SAMPLE_W-1], x}) : {1'b0, x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		mx_s[0]  <= (ay > ax) ? ay : ax;
		rem_s[0] <= (ay > ax) ? ax : ay;
		q_s[0]   <= '0;
		fz_s[0]  <= (ay == '0) && (ax == '0);
		sat_s[0] <= (ay == ax);
		oct_s[0] <= '{swap: (ay > ax), xneg: xneg, yneg: yneg};
	end

	for (genvar i = 1; i <= STEPS; i++) begin : g_step
		logic [MAG_W:0] sh;
		logic           ge;
		assign sh = {rem_s[i-1], 1'b0};
		assign ge = sh >= {1'b0, mx_s[i-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? MAG_W'(sh - {1'b0, mx_s[i-1]}) : sh[MAG_W-1:0];
			q_s[i]   <= {q_s[i-1][RATIO_W-2:0], ge};
			mx_s[i]  <= mx_s[i-1];
			fz_s[i]  <= fz_s[i-1];
			sat_s[i] <= sat_s[i-1];
			oct_s[i] <= oct_s[i-1];
		end
	end

	// both zero gives 0, equal magnitudes saturate just below 1.0
	assign out_v = v_s[STEPS];
	assign oct   = oct_s[STEPS];
	assign ratio = fz_s[STEPS]  ? '0 :
	               sat_s[STEPS] ? '1 : q_s[STEPS];

endmodule
`default_nettype wire

/* sv/atan2a_quot.sv */
`default_nettype none
module atan2a_quot (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_v,
	input  wire logic [atan2a_pkg::POLY_W-1:0] num,
	input  wire logic [atan2a_pkg::POLY_W-1:0] den,
	input  wire atan2a_pkg::oct_t              oct_in,
	output logic                               out_v,
	output logic [atan2a_pkg::BASE_W-1:0]      base,
	output atan2a_pkg::oct_t                   oct_out
);
	import atan2a_pkg::*;

	localparam int STEPS = BASE_W;

	logic              v_s   [0:STEPS];
	logic [REM_W-1:0]  rem_s [0:STEPS];
	logic [POLY_W-1:0] den_s [0:STEPS];
	logic [BASE_W-1:0] q_s   [0:STEPS];
	oct_t              oct_s [0:STEPS];

	// num < den always holds, so each step yields one quotient bit
	assign v_s[0]   = in_v;
	assign rem_s[0] = {1'b0, num};
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign oct_s[0] = oct_in;

	for (genvar i = 1; i <= STEPS; i++) begin : g_step
		logic [REM_W:0] sh;
		logic           ge;
		assign sh = {rem_s[i-1], 1'b0};
		assign ge = sh >= {2'b00, den_s[i-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? REM_W'(sh - {2'b00, den_s[i-1]}) : sh[REM_W-1:0];
			q_s[i]   <= {q_s[i-1][BASE_W-2:0], ge};
			den_s[i] <= den_s[i-1];
			oct_s[i] <= oct_s[i-1];
		end
	end

	assign out_v   = v_s[STEPS];
	assign base    = q_s[STEPS];
	assign oct_out = oct_s[STEPS];

endmodule
`default_nettype wire
